// ===== sv/mrdf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrdf_pkg
// Types and codes shared by the mesh receive dedup/forward block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrdf_pkg;

  localparam int PairW = 32;

  // packet type codes
  localparam logic [1:0] PKT_BEACON = 2'd0;
  localparam logic [1:0] PKT_ACK    = 2'd1;
  localparam logic [1:0] PKT_SENSOR = 2'd2;

  // node role codes
  localparam logic [1:0] ROLE_ROOT   = 2'd0;
  localparam logic [1:0] ROLE_ROUTER = 2'd1;
  localparam logic [1:0] ROLE_LEAF   = 2'd2;

  // disposition codes
  localparam logic [2:0] DISP_IGNORED  = 3'd0;
  localparam logic [2:0] DISP_BEACON   = 3'd1;
  localparam logic [2:0] DISP_ACK_REC  = 3'd2;
  localparam logic [2:0] DISP_DUP      = 3'd3;
  localparam logic [2:0] DISP_DELIVER  = 3'd4;
  localparam logic [2:0] DISP_FORWARD  = 3'd5;
  localparam logic [2:0] DISP_TTL_EXP  = 3'd6;
  localparam logic [2:0] DISP_LEAF_IGN = 3'd7;

  typedef struct packed {
    logic [1:0]  pkt_type;
    logic [15:0] origin_id;
    logic [15:0] seq_num;
    logic [7:0]  hop_ttl;
    logic [47:0] sender_mac;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  disposition;
    logic        ack_req;
    logic [47:0] ack_dest_mac;
    logic [15:0] ack_seq;
    logic [7:0]  forward_ttl;
    logic [15:0] last_acked_seq;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [PairW-1:0] pair;
  } dedup_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } dedup_rsp_t;

endpackage

`default_nettype wire

// ===== sv/mrdf_ram.sv =====
// ----------------------------------------------------------------------------
// mrdf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mrdf_dedup.sv =====
// ----------------------------------------------------------------------------
// mrdf_dedup
// Scans the recent-pair history RAM for a match and inserts on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module mrdf_dedup
  import mrdf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dedup_req_t req,
  output dedup_rsp_t      rsp
);

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                   state_r;
  logic [PairW-1:0]         pair_r;
  logic [IW-1:0]            issue_idx_r;
  logic                     issue_last_r;
  logic                     cmp_vld_r;
  logic [IW-1:0]            cmp_idx_r;
  logic [IW-1:0]            ptr_r;
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic                     done_r;
  logic                     hit_r;

  logic             rd_en;
  logic [PairW-1:0] rd_data;
  logic             hit_now;
  logic             wr_en;

  assign rd_en = (state_r == ST_SCAN) && !issue_last_r;

  // an entry never written holds the cleared pair of zeros
  assign hit_now = valid_r[cmp_idx_r] ? (rd_data == pair_r) : (pair_r == '0);

  assign wr_en = (state_r == ST_SCAN) && cmp_vld_r && !hit_now && (cmp_idx_r == LAST_IDX);

  mrdf_ram #(
    .WIDTH (PairW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ptr_r),
    .wdata (pair_r),
    .re    (rd_en),
    .raddr (issue_idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_idx_r  <= '0;
      issue_last_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      ptr_r        <= '0;
      valid_r      <= '0;
      done_r       <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            pair_r       <= req.pair;
            issue_idx_r  <= '0;
            issue_last_r <= 1'b0;
            cmp_vld_r    <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // advance the read side one entry per cycle
          cmp_vld_r <= rd_en;
          cmp_idx_r <= issue_idx_r;
          done_r    <= cmp_vld_r && (hit_now || (cmp_idx_r == LAST_IDX));
          if (rd_en) begin
            if (issue_idx_r == LAST_IDX) begin
              issue_last_r <= 1'b1;
            end else begin
              issue_idx_r <= issue_idx_r + 1'b1;
            end
          end
          // compare side, working on the entry read in the previous cycle
          if (cmp_vld_r) begin
            if (hit_now) begin
              hit_r   <= 1'b1;
              state_r <= ST_IDLE;
            end else if (cmp_idx_r == LAST_IDX) begin
              valid_r[ptr_r] <= 1'b1;
              ptr_r   <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
              hit_r   <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;

endmodule

`default_nettype wire

// ===== sv/mesh_rx_dedup_forward.sv =====
// ----------------------------------------------------------------------------
// mesh_rx_dedup_forward
// Receive-side handling of one mesh packet with duplicate suppression.
// ----------------------------------------------------------------------------
// Beacon, ACK and other packets give their result strobe in the cycle after
// they are taken; busy stays low for them. A sensor packet raises busy and
// walks the history RAM one entry per cycle (registered read, compare in the
// cycle after each read), then writes a missed pair at the ring pointer; a
// hit ends the walk at the matching entry. Each result is on out_item for
// exactly one cycle with out_strobe, and must be taken then; the receiver has
// no way to hold it. Write cfg_wdata with cfg_we only while no sensor packet
// is in flight.
`default_nettype none

module mesh_rx_dedup_forward
  import mrdf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_strobe,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  logic        busy_r;
  logic [1:0]  role_r;
  logic [15:0] acked_r;
  in_item_t    item_r;
  logic        strobe_r;
  out_item_t   out_r;

  logic       accept;
  dedup_req_t dreq;
  dedup_rsp_t drsp;
  logic       strobe_nxt;
  out_item_t  out_nxt;

  assign accept     = start && !busy_r;
  assign dreq.start = accept && (in_item.pkt_type == PKT_SENSOR);
  assign dreq.pair  = {in_item.origin_id, in_item.seq_num};

  assign strobe_nxt = (accept && (in_item.pkt_type != PKT_SENSOR)) || (busy_r && drsp.done);

  mrdf_dedup #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dedup (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    out_nxt                = '0;
    out_nxt.last_acked_seq = acked_r;
    if (busy_r) begin
      out_nxt.ack_req      = 1'b1;
      out_nxt.ack_dest_mac = item_r.sender_mac;
      out_nxt.ack_seq      = item_r.seq_num;
      priority if (drsp.hit) begin
        out_nxt.disposition = DISP_DUP;
      end else if (role_r == ROLE_ROOT) begin
        out_nxt.disposition = DISP_DELIVER;
      end else if (role_r == ROLE_ROUTER) begin
        if (item_r.hop_ttl <= 8'd1) begin
          out_nxt.disposition = DISP_TTL_EXP;
        end else begin
          out_nxt.disposition = DISP_FORWARD;
          out_nxt.forward_ttl = item_r.hop_ttl - 8'd1;
        end
      end else begin
        // unused role code behaves as leaf
        out_nxt.disposition = DISP_LEAF_IGN;
      end
    end else begin
      unique case (in_item.pkt_type)
        PKT_BEACON: begin
          out_nxt.disposition = DISP_BEACON;
        end
        PKT_ACK: begin
          out_nxt.disposition    = DISP_ACK_REC;
          out_nxt.last_acked_seq = in_item.seq_num;
        end
        default: begin
          out_nxt.disposition = DISP_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      role_r   <= ROLE_LEAF;
      acked_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        role_r <= cfg_wdata;
      end
      if (accept) begin
        item_r <= in_item;
        if (in_item.pkt_type == PKT_ACK) begin
          acked_r <= in_item.seq_num;
        end
        if (in_item.pkt_type == PKT_SENSOR) begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && drsp.done) begin
        busy_r <= 1'b0;
      end
      if (strobe_nxt) begin
        out_r <= out_nxt;
      end
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire
